// File: rtl/ctht_pkg.sv
package ctht_pkg;

    localparam int          DEPTH_DEFAULT = 4096;
    localparam logic [31:0] EMPTY_ADDR    = 32'hFFFF_FFFF;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] TCP_TIMEOUT_RST = 16'd300;
    localparam logic [15:0] UDP_TIMEOUT_RST = 16'd60;

    localparam logic CFG_TCP_TIMEOUT = 1'b0;
    localparam logic CFG_UDP_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        OUT_MISS      = 3'd0,
        OUT_HIT       = 3'd1,
        OUT_EVICTED   = 3'd2,
        OUT_INSERTED  = 3'd3,
        OUT_REFRESHED = 3'd4,
        OUT_REFUSED   = 3'd5,
        OUT_IGNORED   = 3'd6
    } t_outcome;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_EVAL
    } t_bstate;

    typedef struct packed {
        logic        op;
        logic        ignore;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] ports;
        logic [7:0]  proto;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] ports;
        logic [7:0]  proto;
        logic [31:0] last;
    } t_slot;

    typedef struct packed {
        logic [15:0] tcp;
        logic [15:0] udp;
    } t_timeouts;

endpackage

// File: rtl/ctht_front.sv
module ctht_front #(
    parameter int DEPTH = ctht_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [31:0]       i_src_addr,
    input  logic [31:0]       i_dst_addr,
    input  logic [15:0]       i_src_port_num,
    input  logic [15:0]       i_dst_port_num,
    input  logic [7:0]        i_proto_num,
    input  logic [31:0]       i_now_seconds,
    input  logic              i_full,
    output logic              o_push,
    output ctht_pkg::t_req    o_req,
    output logic [IW-1:0]     o_idx,
    output logic              o_busy
);
    import ctht_pkg::*;

    localparam bit          IS_POW2 = (DEPTH & (DEPTH - 1)) == 0;
    localparam logic [63:0] RECIP_W = (64'd1 << (32 + IW)) / 64'(DEPTH);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];
    localparam logic [31:0] DEPTH_C = 32'(DEPTH);

    t_fstate         r_state, n_state;
    t_req            r_req, n_req;
    logic [31:0]     r_hash, n_hash;
    logic [64:0]     r_acc, n_acc;
    logic [31:0]     r_part, n_part;
    logic [1:0]      r_step, n_step;
    logic [IW-1:0]   r_idx, n_idx;

    logic            swap;
    logic [31:0]     lo, hi, ports, hash;
    logic [15:0]     mul_in;
    logic [48:0]     prod;
    logic [31:0]     quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_req  <= n_req;
        r_hash <= n_hash;
        r_acc  <= n_acc;
        r_part <= n_part;
        r_step <= n_step;
        r_idx  <= n_idx;
    end

    always_comb begin
        swap    = !((i_src_addr < i_dst_addr) ||
                    (i_src_addr == i_dst_addr && i_src_port_num <= i_dst_port_num));
        lo      = swap ? i_dst_addr : i_src_addr;
        hi      = swap ? i_src_addr : i_dst_addr;
        ports   = swap ? {i_dst_port_num, i_src_port_num} : {i_src_port_num, i_dst_port_num};
        hash    = lo ^ hi ^ ports ^ {i_proto_num, 24'd0};
        mul_in  = (r_step == 2'd0) ? r_hash[15:0] : r_hash[31:16];
        prod    = mul_in * RECIP;
        quot    = 32'(r_acc >> (32 + IW));

        n_state = r_state;
        n_req   = r_req;
        n_hash  = r_hash;
        n_acc   = r_acc;
        n_part  = r_part;
        n_step  = r_step;
        n_idx   = r_idx;
        o_push  = 1'b0;

        case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_req.op     = i_op;
                    n_req.ignore = (i_proto_num != PROTO_TCP) && (i_proto_num != PROTO_UDP);
                    n_req.lo     = lo;
                    n_req.hi     = hi;
                    n_req.ports  = ports;
                    n_req.proto  = i_proto_num;
                    n_req.now    = i_now_seconds;
                    n_hash       = hash;
                    n_idx        = hash[IW-1:0];
                    n_step       = 2'd0;
                    n_state      = (IS_POW2 || n_req.ignore) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                // quotient estimate by reciprocal, low then high half of the hash, then remainder and correction
                case (r_step)
                    2'd0: begin
                        n_acc  = 65'(prod);
                        n_step = 2'd1;
                    end
                    2'd1: begin
                        n_acc  = r_acc + {prod, 16'd0};
                        n_step = 2'd2;
                    end
                    2'd2: begin
                        n_part = r_hash - quot * DEPTH_C;
                        n_step = 2'd3;
                    end
                    default: begin
                        n_idx   = (r_part >= DEPTH_C) ? IW'(r_part - DEPTH_C) : IW'(r_part);
                        n_state = F_PUSH;
                    end
                endcase
            end
            F_PUSH: begin
                o_push = 1'b1;
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_req  = r_req;
    assign o_idx  = r_idx;
    assign o_busy = r_state != F_IDLE;

endmodule

// File: rtl/ctht_queue.sv
module ctht_queue #(
    parameter int IW = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ctht_pkg::t_req    i_req,
    input  logic [IW-1:0]     i_idx,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output ctht_pkg::t_req    o_req,
    output logic [IW-1:0]     o_idx
);
    import ctht_pkg::*;

    t_req          r_req [2];
    logic [IW-1:0] r_idx [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) begin
            r_req[r_wp] <= i_req;
            r_idx[r_wp] <= i_idx;
        end
    end

    assign o_req = r_req[r_rp];
    assign o_idx = r_idx[r_rp];

endmodule

// File: rtl/ctht_back.sv
module ctht_back #(
    parameter int DEPTH = ctht_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctht_pkg::t_timeouts  i_tmo,
    input  logic                 i_empty,
    input  ctht_pkg::t_req       i_req,
    input  logic [IW-1:0]        i_idx,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_valid,
    output logic                 o_found,
    output ctht_pkg::t_outcome   o_outcome
);
    import ctht_pkg::*;

    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

    t_slot          mem [DEPTH];
    t_slot          r_rd;

    t_bstate        r_state, n_state;
    t_req           r_cur, n_cur;
    logic [IW-1:0]  r_idx, n_idx;
    logic [IW-1:0]  r_cnt, n_cnt;
    logic [OW-1:0]  r_occ, n_occ;
    logic           r_valid, n_valid;
    logic           r_found, n_found;
    t_outcome       r_outcome, n_outcome;

    logic           rd_en, wr_en;
    logic [IW-1:0]  wr_addr;
    t_slot          wr_data;
    logic           empty, expired, match;
    logic [31:0]    age;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_idx   <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
        r_cur     <= n_cur;
        r_cnt     <= n_cnt;
        r_found   <= n_found;
        r_outcome <= n_outcome;
    end

    always_comb begin
        empty = r_rd.lo == EMPTY_ADDR && r_rd.hi == EMPTY_ADDR;
        age   = r_cur.now - r_rd.last;
        if (r_rd.proto == PROTO_TCP) begin
            expired = age > {16'd0, i_tmo.tcp};
        end else if (r_rd.proto == PROTO_UDP) begin
            expired = age > {16'd0, i_tmo.udp};
        end else begin
            expired = 1'b1;
        end
        match = r_rd.lo == r_cur.lo && r_rd.hi == r_cur.hi &&
                r_rd.ports == r_cur.ports && r_rd.proto == r_cur.proto;

        n_state   = r_state;
        n_cur     = r_cur;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_occ     = r_occ;
        n_valid   = 1'b0;
        n_found   = 1'b0;
        n_outcome = OUT_MISS;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_rd;

        case (r_state)
            B_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '{lo: EMPTY_ADDR, hi: EMPTY_ADDR, ports: '0, proto: '0, last: '0};
                n_idx   = r_idx + IW'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cur = i_req;
                    n_idx = i_idx;
                    n_cnt = '0;
                    if (i_req.ignore) begin
                        n_valid   = 1'b1;
                        n_outcome = OUT_IGNORED;
                    end else if (i_req.op && r_occ >= FULL_OCC) begin
                        n_valid   = 1'b1;
                        n_outcome = OUT_REFUSED;
                    end else begin
                        n_state = B_READ;
                    end
                end
            end
            B_READ: begin
                rd_en   = 1'b1;
                n_state = B_EVAL;
            end
            B_EVAL: begin
                n_state = B_IDLE;
                n_valid = 1'b1;
                if (!r_cur.op && empty) begin
                    n_outcome = OUT_MISS;
                end else if (!r_cur.op && expired) begin
                    wr_en      = 1'b1;
                    wr_data.lo = EMPTY_ADDR;
                    wr_data.hi = EMPTY_ADDR;
                    if (r_occ != '0) begin
                        n_occ = r_occ - OW'(1);
                    end
                    n_outcome = OUT_EVICTED;
                end else if (!r_cur.op && match) begin
                    wr_en        = 1'b1;
                    wr_data.last = r_cur.now;
                    n_found      = 1'b1;
                    n_outcome    = OUT_HIT;
                end else if (r_cur.op && empty) begin
                    wr_en     = 1'b1;
                    wr_data   = '{lo: r_cur.lo, hi: r_cur.hi, ports: r_cur.ports,
                                  proto: r_cur.proto, last: r_cur.now};
                    n_occ     = r_occ + OW'(1);
                    n_outcome = OUT_INSERTED;
                end else if (r_cur.op && match) begin
                    wr_en        = 1'b1;
                    wr_data.last = r_cur.now;
                    n_outcome    = OUT_REFRESHED;
                end else if (r_cnt == LAST_IDX) begin
                    n_outcome = r_cur.op ? OUT_REFUSED : OUT_MISS;
                end else begin
                    n_valid = 1'b0;
                    n_cnt   = r_cnt + IW'(1);
                    n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
                    n_state = B_READ;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_clearing = r_state == B_CLEAR;
    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_outcome  = r_outcome;

endmodule

// File: rtl/connection_tracking_hash_table.sv
// flow: the front registers an accepted request and its start index, the low hash bits or
// the hash remainder by reciprocal when TABLE_DEPTH is not a power of two, pushes it into
// the 2-entry queue and takes no new request until the push is done; the back pops one
// request at a time, reads then evaluates each probed slot in turn; ignored requests skip
// remainder and probe. reset: timeouts return to 300 and 60 s, then a clearing pass empties
// every slot while busy stays high; results strobe on o_valid, no receiver stall
module connection_tracking_hash_table #(
    parameter int TABLE_DEPTH = ctht_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_op,
    input  logic [31:0]         i_src_addr,
    input  logic [31:0]         i_dst_addr,
    input  logic [15:0]         i_src_port_num,
    input  logic [15:0]         i_dst_port_num,
    input  logic [7:0]          i_proto_num,
    input  logic [31:0]         i_now_seconds,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    output logic                o_found,
    output ctht_pkg::t_outcome  o_outcome
);
    import ctht_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    t_timeouts      r_tmo;
    logic           front_busy, clearing, push, full, q_empty, pop;
    t_req           f_req, q_req;
    logic [IW-1:0]  f_idx, q_idx;

    assign o_cfg_ready = 1'b1;
    assign busy        = front_busy || clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo.tcp <= TCP_TIMEOUT_RST;
            r_tmo.udp <= UDP_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TCP_TIMEOUT: r_tmo.tcp <= i_cfg_data;
                CFG_UDP_TIMEOUT: r_tmo.udp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ctht_front #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (start && !busy),
        .i_op           (i_op),
        .i_src_addr     (i_src_addr),
        .i_dst_addr     (i_dst_addr),
        .i_src_port_num (i_src_port_num),
        .i_dst_port_num (i_dst_port_num),
        .i_proto_num    (i_proto_num),
        .i_now_seconds  (i_now_seconds),
        .i_full         (full),
        .o_push         (push),
        .o_req          (f_req),
        .o_idx          (f_idx),
        .o_busy         (front_busy)
    );

    ctht_queue #(.IW(IW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .i_idx   (f_idx),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_req   (q_req),
        .o_idx   (q_idx)
    );

    ctht_back #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tmo      (r_tmo),
        .i_empty    (q_empty),
        .i_req      (q_req),
        .i_idx      (q_idx),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_outcome  (o_outcome)
    );

endmodule

// File: rtl/ctht_checker.sv
module ctht_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic                o_found,
    input ctht_pkg::t_outcome  o_outcome
);
    import ctht_pkg::*;

    a_found_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_outcome == OUT_HIT)
        else $error("found without hit");

    a_hit_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome == OUT_HIT |-> o_found)
        else $error("hit without found");

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy during clearing pass");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");

endmodule

bind connection_tracking_hash_table ctht_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_found   (o_found),
    .o_outcome (o_outcome)
);
